@@ hw/rtl/aes256_pkg.sv @@
// package: types, constants and byte functions for the aes-256 cipher unit
`default_nettype none
package aes256_pkg;

   localparam int NumRounds = 14;
   localparam int NumRkeys  = 15;
   localparam int RkIdxW    = 4;
   localparam int CsrIdxW   = 2;

   localparam logic [1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [1:0] CSR_KEY_WORD_3 = 2'd3;

   localparam logic ACTION_ENCRYPT = 1'b0;
   localparam logic ACTION_DECRYPT = 1'b1;

   typedef logic [7:0]   byte_type;
   typedef logic [127:0] block_type;
   typedef logic [31:0]  word_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] ISBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // multiply by x in gf(2^8)
   function automatic byte_type xt(input byte_type a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a state held with byte 0 in the top bits
   function automatic byte_type get_byte(input block_type s, input int i);
      get_byte = s[127 - 8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) & 3)*4 + r)];
         end
      end
      sub_shift = o;
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127 - 8*(((c + r) & 3)*4 + r) -: 8] = ISBOX[get_byte(s, c*4 + r)];
         end
      end
      inv_shift_sub = o;
   endfunction

   function automatic block_type mix(input block_type s);
      block_type o;
      byte_type a0, a1, a2, a3;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4 + 1);
         a2 = get_byte(s, c*4 + 2);
         a3 = get_byte(s, c*4 + 3);
         o[127 - 8*(c*4)     -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         o[127 - 8*(c*4 + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         o[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         o[127 - 8*(c*4 + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      mix = o;
   endfunction

   // inverse mix as a premultiply by (4x^2+5) followed by forward mix
   function automatic block_type inv_mix(input block_type s);
      block_type o;
      byte_type a0, a1, a2, a3, u, v;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4 + 1);
         a2 = get_byte(s, c*4 + 2);
         a3 = get_byte(s, c*4 + 3);
         u = xt(xt(a0 ^ a2));
         v = xt(xt(a1 ^ a3));
         o[127 - 8*(c*4)     -: 8] = a0 ^ u;
         o[127 - 8*(c*4 + 1) -: 8] = a1 ^ v;
         o[127 - 8*(c*4 + 2) -: 8] = a2 ^ u;
         o[127 - 8*(c*4 + 3) -: 8] = a3 ^ v;
      end
      inv_mix = mix(o);
   endfunction

   function automatic word_type sub_word(input word_type w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aes256_block_cipher_unit.sv @@
// top level: iterative aes-256 ecb cipher with round key store and key schedule
//
// usage
//   csr channel: csr_valid/csr_ready with csr_index (0..3) and csr_data write the
//   four 64-bit key words; key byte 0 sits in bits 7:0 of key word 0. csr_ready
//   is high only while the unit is idle and req_valid is low.
//   req channel: one word is a block (req_block_high/req_block_low, byte 0 in
//   bits 63:56 of the high half) and req_action (0 encrypt, 1 decrypt).
//   rsp channel: rsp_result_high/rsp_result_low, same byte order.
// key schedule and block flow
//   after reset and after every key write the key schedule runs, one 32-bit
//   schedule word per cycle, while req_stall is high.
//   a block passes through the shared round unit: the first key addition
//   with the load, then 14 rounds, one stored round key read per cycle.
//   the result sits in an output register; the next block is taken as soon as
//   the rounds are done and the output register is free or being drained, so
//   no block enters the round unit before the last one has finished its rounds.
// reset and stall
//   reset clears all control state and starts the zero-key schedule.
//   while rsp_stall is high the result holds; one more block may be taken and
//   then waits in its last round with req_stall high until the result leaves.
`default_nettype none
module aes256_block_cipher_unit
   import aes256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [63:0] csr_data
);

   typedef enum logic [1:0] {ST_EXPAND, ST_IDLE, ST_RUN} state_type;

   state_type          state_ff, state_in;
   logic [63:0]        key_ff [4];
   logic [31:0]        sched_ff [8];
   logic [5:0]         widx_ff;
   logic [7:0]         rcon_ff;
   logic [127:0]       rk_acc_ff;
   logic [127:0]       rk_mem [NumRkeys];
   logic [127:0]       rk_rd_ff;
   logic [RkIdxW-1:0]  rd_addr;
   logic [RkIdxW-1:0]  round_ff;
   logic               dec_ff;
   block_type          st_ff;
   logic               rsp_valid_ff;
   logic [127:0]       rsp_ff;
   logic               take_req, out_free, last_round;
   logic [31:0]        tword, nword;
   block_type          round_out;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE);
   assign take_req  = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign last_round = (round_ff == RkIdxW'(NumRounds));

   // key schedule word generation
   always_comb begin
      tword = sched_ff[7];
      if (widx_ff[2:0] == 3'd0) begin
         tword = sub_word({tword[23:0], tword[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (widx_ff[2:0] == 3'd4) begin
         tword = sub_word(tword);
      end
      nword = sched_ff[0] ^ tword;
   end

   // shared round unit; rk_rd_ff holds the key for round_ff
   always_comb begin
      if (!dec_ff) begin
         round_out = sub_shift(st_ff);
         if (!last_round) round_out = mix(round_out);
         round_out = round_out ^ rk_rd_ff;
      end else begin
         round_out = inv_shift_sub(st_ff) ^ rk_rd_ff;
         if (!last_round) round_out = inv_mix(round_out);
      end
   end

   // read address: key for the next cycle
   always_comb begin
      if (state_ff == ST_RUN) begin
         rd_addr = dec_ff ? RkIdxW'(NumRounds) - round_ff - RkIdxW'(1)
                          : round_ff + RkIdxW'(1);
      end else begin
         rd_addr = req_action ? RkIdxW'(NumRounds) - RkIdxW'(1) : RkIdxW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EXPAND: if (widx_ff == 6'd60) state_in = ST_IDLE;
         ST_IDLE: begin
            if (csr_valid && csr_ready && csr_index <= CSR_KEY_WORD_3) state_in = ST_EXPAND;
            else if (take_req) state_in = ST_RUN;
         end
         ST_RUN: if (last_round && out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // round key store: 4 schedule words packed per entry
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXPAND && widx_ff[1:0] == 2'd0 && widx_ff != 6'd0) begin
         rk_mem[widx_ff[5:2] - RkIdxW'(1)] <= {rk_acc_ff[95:0], sched_ff[7]};
      end
      if (take_req) begin
         rk_rd_ff <= rk_mem[rd_addr];
      end else if (state_ff == ST_RUN && !last_round) begin
         rk_rd_ff <= rk_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXPAND;
         rsp_valid_ff <= 1'b0;
         widx_ff      <= 6'd0;
         rcon_ff      <= 8'h01;
         round_ff     <= '0;
         dec_ff       <= 1'b0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         for (int i = 0; i < 8; i++) sched_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall && !(state_ff == ST_RUN && last_round)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_EXPAND: begin
               // widx 0..7 load key words, 8..59 generate, 60 stores the last entry
               widx_ff <= widx_ff + 6'd1;
               for (int i = 0; i < 7; i++) sched_ff[i] <= sched_ff[i + 1];
               if (widx_ff < 6'd8) begin
                  sched_ff[7] <= {key_ff[widx_ff[2:1]][32*widx_ff[0] +: 8],
                                  key_ff[widx_ff[2:1]][32*widx_ff[0] + 8 +: 8],
                                  key_ff[widx_ff[2:1]][32*widx_ff[0] + 16 +: 8],
                                  key_ff[widx_ff[2:1]][32*widx_ff[0] + 24 +: 8]};
               end else begin
                  sched_ff[7] <= nword;
                  if (widx_ff[2:0] == 3'd0) rcon_ff <= xt(rcon_ff);
               end
               rk_acc_ff <= {rk_acc_ff[95:0], sched_ff[7]};
            end
            ST_IDLE: begin
               if (csr_valid && csr_ready && csr_index <= CSR_KEY_WORD_3) begin
                  key_ff[csr_index] <= csr_data;
                  widx_ff           <= 6'd0;
                  rcon_ff           <= 8'h01;
               end else if (take_req) begin
                  dec_ff   <= req_action;
                  round_ff <= RkIdxW'(1);
                  st_ff    <= {req_block_high, req_block_low} ^ rk_mem[req_action ?
                              RkIdxW'(NumRounds) : RkIdxW'(0)];
               end
            end
            ST_RUN: begin
               if (!last_round) begin
                  st_ff    <= round_out;
                  round_ff <= round_ff + RkIdxW'(1);
               end else if (out_free) begin
                  rsp_ff       <= round_out;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_ff[127:64];
   assign rsp_result_low  = rsp_ff[63:0];

endmodule
`default_nettype wire

@@ hw/rtl/aes256_checker.sv @@
// checker: port-level properties of the cipher unit, bound to the top level
`default_nettype none
module aes256_checker
   import aes256_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_result_high,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_high))
      else $error("stalled result word changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !csr_ready)
      else $error("unit took a second word while busy");

   a_no_rsp_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !req_stall)
      else $error("csr ready while data path busy");

endmodule

bind aes256_block_cipher_unit aes256_checker u_aes256_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_high(rsp_result_high),
   .csr_valid(csr_valid), .csr_ready(csr_ready)
);
`default_nettype wire

@@ tb/sv/aes256_block_cipher_unit_test.sv @@
// testbench: aes-256 ecb encrypt and decrypt against a behavioral cipher, several keys
`default_nettype none
module aes256_block_cipher_unit_test;
   import aes256_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        action;
      logic [63:0] blk_hi;
      logic [63:0] blk_lo;
   } block_word_type;

   typedef struct {
      logic [63:0] res_hi;
      logic [63:0] res_lo;
   } cipher_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   aes256_block_cipher_unit DUT (.*);

   always #5 clock = ~clock;

   logic [7:0]  fwd_sub [256];
   logic [7:0]  inv_sub [256];
   logic [63:0] key_copy [4];
   logic [7:0]  round_keys [15][16];

   block_word_type  block_queue [$];
   cipher_word_type cipher_queue [$];
   int  errors = 0;
   int  words_out = 0;
   bit  quiet = 1'b0;
   bit  req_taken = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = xtime(a);
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
      return (b << n) | (b >> (8 - n));
   endfunction

   function automatic void build_boxes();
      logic [7:0] iv, s;
      for (int b = 0; b < 256; b++) begin
         iv = 8'h00;
         for (int c = 1; c < 256; c++) begin
            if (b != 0 && gf_mul(b[7:0], c[7:0]) == 8'h01) iv = c[7:0];
         end
         s = iv ^ rotl8(iv, 1) ^ rotl8(iv, 2) ^ rotl8(iv, 3) ^ rotl8(iv, 4) ^ 8'h63;
         fwd_sub[b] = s;
         inv_sub[s] = b[7:0];
      end
   endfunction

   function automatic void expand_key();
      logic [7:0] w [240];
      logic [7:0] t [4];
      logic [7:0] tmp, rc;
      rc = 8'h01;
      for (int i = 0; i < 32; i++) w[i] = key_copy[i >> 3][8*(i & 7) +: 8];
      for (int i = 8; i < 60; i++) begin
         for (int b = 0; b < 4; b++) t[b] = w[4*(i-1) + b];
         if ((i & 7) == 0) begin
            tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
            for (int b = 0; b < 4; b++) t[b] = fwd_sub[t[b]];
            t[0] ^= rc;
            rc = xtime(rc);
         end else if ((i & 7) == 4) begin
            for (int b = 0; b < 4; b++) t[b] = fwd_sub[t[b]];
         end
         for (int b = 0; b < 4; b++) w[4*i + b] = w[4*(i-8) + b] ^ t[b];
      end
      for (int r = 0; r < 15; r++)
         for (int i = 0; i < 16; i++) round_keys[r][i] = w[16*r + i];
   endfunction

   function automatic cipher_word_type aes_block(input block_word_type wd);
      logic [7:0] s [16];
      logic [7:0] o [16];
      logic [7:0] col [4];
      logic [7:0] fm [4];
      logic [7:0] im [4];
      logic [7:0] acc;
      cipher_word_type res;
      fm = '{8'd2, 8'd3, 8'd1, 8'd1};
      im = '{8'd14, 8'd11, 8'd13, 8'd9};
      for (int i = 0; i < 8; i++) begin
         s[i]     = wd.blk_hi[56 - 8*i +: 8];
         s[i + 8] = wd.blk_lo[56 - 8*i +: 8];
      end
      if (wd.action == ACTION_ENCRYPT) begin
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[0][i];
         for (int r = 1; r <= 14; r++) begin
            for (int i = 0; i < 16; i++) o[i] = fwd_sub[s[i]];
            for (int c = 0; c < 4; c++)
               for (int q = 0; q < 4; q++) s[c*4 + q] = o[((c + q) & 3)*4 + q];
            if (r != 14) begin
               for (int c = 0; c < 4; c++) begin
                  for (int k = 0; k < 4; k++) col[k] = s[c*4 + k];
                  for (int q = 0; q < 4; q++) begin
                     acc = 8'h00;
                     for (int k = 0; k < 4; k++) acc ^= gf_mul(fm[(k - q + 4) & 3], col[k]);
                     s[c*4 + q] = acc;
                  end
               end
            end
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][i];
         end
      end else begin
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[14][i];
         for (int r = 13; r >= 0; r--) begin
            o = s;
            for (int c = 0; c < 4; c++)
               for (int q = 0; q < 4; q++) s[((c + q) & 3)*4 + q] = o[c*4 + q];
            for (int i = 0; i < 16; i++) s[i] = inv_sub[s[i]] ^ round_keys[r][i];
            if (r != 0) begin
               for (int c = 0; c < 4; c++) begin
                  for (int k = 0; k < 4; k++) col[k] = s[c*4 + k];
                  for (int q = 0; q < 4; q++) begin
                     acc = 8'h00;
                     for (int k = 0; k < 4; k++) acc ^= gf_mul(im[(k - q + 4) & 3], col[k]);
                     s[c*4 + q] = acc;
                  end
               end
            end
         end
      end
      for (int i = 0; i < 8; i++) begin
         res.res_hi[56 - 8*i +: 8] = s[i];
         res.res_lo[56 - 8*i +: 8] = s[i + 8];
      end
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin
      block_word_type wd;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (block_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
            wd = block_queue.pop_front();
            req_action     <= wd.action;
            req_block_high <= wd.blk_hi;
            req_block_low  <= wd.blk_lo;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random stalls, plus one long hold-off to back up the unit
   always @(negedge clock) begin
      if (!hold_done && words_out >= 500) begin
         hold_done = 1'b1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 12);
      end
   end

   // accepted request words and response check
   always @(posedge clock) begin
      block_word_type  wd;
      cipher_word_type want;
      if (!reset && req_valid && !req_stall) begin
         wd.action = req_action;
         wd.blk_hi = req_block_high;
         wd.blk_lo = req_block_low;
         cipher_queue.push_back(aes_block(wd));
         req_taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (cipher_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h %h", rsp_result_high, rsp_result_low);
         end else begin
            want = cipher_queue.pop_front();
            if (want.res_hi !== rsp_result_high || want.res_lo !== rsp_result_low) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h %h actual %h %h",
                           want.res_hi, want.res_lo, rsp_result_high, rsp_result_low);
            end
         end
      end
   end

   task automatic wait_drained();
      while (block_queue.size() > 0 || req_valid || cipher_queue.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      key_copy[idx] = val;
      expand_key();
   endtask

   task automatic push_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
      block_word_type wd;
      wd.action = act;
      wd.blk_hi = hi;
      wd.blk_lo = lo;
      block_queue.push_back(wd);
   endtask

   task automatic push_random(input int n);
      for (int i = 0; i < n; i++)
         push_block($urandom_range(0, 1), {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   initial begin
      logic [63:0] keyset [4][4];
      build_boxes();
      for (int i = 0; i < 4; i++) key_copy[i] = '0;
      expand_key();
      keyset[0] = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                    64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
      keyset[1] = '{64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                    64'h1716151413121110, 64'h1f1e1d1c1b1a1918};
      keyset[2] = '{{$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}};
      keyset[3] = '{64'h0, 64'h0, 64'h0, 64'h0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset key, directed and random blocks
      push_block(ACTION_ENCRYPT, 64'h0, 64'h0);
      push_block(ACTION_DECRYPT, 64'h0, 64'h0);
      push_block(ACTION_ENCRYPT, '1, '1);
      push_block(ACTION_DECRYPT, '1, '1);
      push_block(ACTION_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
      push_block(ACTION_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
      push_block(ACTION_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
      push_block(ACTION_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
      push_block(ACTION_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      push_block(ACTION_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      push_random(380);
      wait_drained();

      for (int k = 0; k < 4; k++) begin
         for (int w = 0; w < 4; w++) write_key(w[1:0], keyset[k][w]);
         if (k == 1) begin
            push_block(ACTION_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
            push_block(ACTION_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
         end
         if (k == 2) quiet = 1'b1;
         push_random(385);
         wait_drained();
         quiet = 1'b0;
      end
      // single word change re-expands the whole schedule
      write_key(CSR_KEY_WORD_2, {$urandom, $urandom});
      push_random(10);
      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
